// File: rtl/core/table_lagrange_interpolator_top_macros.svh
// assertion helpers for the controller rtl
`ifndef TABLE_LAGRANGE_INTERPOLATOR_TOP_MACROS_SVH
`define TABLE_LAGRANGE_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication
`define TLI_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tli assertion failed");

// next-cycle implication
`define TLI_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tli assertion failed");

`endif

// File: rtl/core/tli_pkg.sv
package tli_pkg;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes
   localparam logic [1:0] REG_ORDER  = 2'd0;
   localparam logic [1:0] REG_LENGTH = 2'd1;
   localparam logic [1:0] REG_LOW    = 2'd2;
   localparam logic [1:0] REG_HIGH   = 2'd3;

   localparam logic [1:0]  ORDER_RESET  = 2'd1;
   localparam logic [11:0] LENGTH_RESET = 12'd0;
   localparam logic [31:0] LOW_RESET    = 32'hA000_0000;
   localparam logic [31:0] HIGH_RESET   = 32'hFFFF_D275;

   localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;

   // datapath widths
   localparam int MAGW      = 33;   // node difference magnitude
   localparam int NUMW      = 99;   // product of three differences
   localparam int PW        = 105;  // multiplier product
   localparam int BW        = 41;   // multiplier operand walked bit by bit
   localparam int DVDW      = 130;  // dividend after the 2^31 scale
   localparam int DSHIFT    = 31;
   localparam int REMW      = 100;
   localparam int QW        = 42;
   localparam int ACCW      = 107;
   localparam int FRAC      = 30;
   localparam int DIV_STEPS = 130;

   localparam logic [BW-1:0]   WEIGHT_LIMIT = 41'h100_0000_0000;
   localparam logic [ACCW:0]   ROUND_HALF   = (ACCW+1)'(64'h2000_0000);

   typedef struct packed {
      logic              req_type;
      logic [10:0]       entry_index;
      logic signed [31:0] log_scale;
      logic [63:0]       ratio_value;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] ratio_out;
      logic        out_of_bounds;
      logic        at_table_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]         interp_order;
      logic [11:0]        table_length;
      logic signed [31:0] log_scale_low;
      logic signed [31:0] log_scale_high;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_WRITE,
      OP_CAPTURE,
      OP_SCAN,
      OP_NODE,
      OP_WINIT,
      OP_MSTART_NUM,
      OP_MSTART_DEN,
      OP_MSTART_W,
      OP_MSTEP,
      OP_MEND_NUM,
      OP_MEND_DEN,
      OP_DSTART,
      OP_DSTEP,
      OP_DEND,
      OP_ACC,
      OP_FIN,
      OP_OUT_OOB,
      OP_OUT_END,
      OP_OUT_DUP,
      OP_OUT_SUM
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN0,
      ST_SCAN,
      ST_PLAN,
      ST_END_RD,
      ST_END_OUT,
      ST_NODE,
      ST_DUP,
      ST_WINIT,
      ST_JSEL,
      ST_MNUM,
      ST_MNUM_RUN,
      ST_MDEN,
      ST_MDEN_RUN,
      ST_DIV,
      ST_DIV_RUN,
      ST_DEND,
      ST_MW,
      ST_MW_RUN,
      ST_FIN,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] slot;
      logic [2:0] m;
      logic [1:0] k;
      logic [1:0] j;
   } dp_cmd_type;

   typedef struct packed {
      logic oob_bounds;
      logic pair_hit;
      logic ge_last;
      logic dup;
      logic mul_done;
   } dp_status_type;

   // sign in the top bit, magnitude of a - b below
   function automatic logic [MAGW:0] sub_mag(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
      logic signed [32:0] d;
      d = 33'(a) - 33'(b);
      sub_mag = d[32] ? {1'b1, 33'(-d)} : {1'b0, d};
   endfunction

endpackage

// File: rtl/core/table_lagrange_interpolator_top.sv
// table interpolator: a sorted table of (log scale, ratio) pairs answers
// lagrange interpolation queries of order 1 to 3.
// request channel: req_data is taken at a rising edge with start high and
// busy low. a load request writes one table slot; busy stays low. a query
// outside the configured bounds (or with an empty table) answers 1.0 with
// out_of_bounds set in the cycle after the start. a query inside the table
// scans the abscissas one memory read a cycle, then reads the stencil. at
// the table end the last ratio is returned. otherwise each of the m stencil
// nodes needs 2*(m-1) serial multiplies, a restoring division and one
// weight multiply; the multiplier and divider work one bit a cycle.
// result channel: rsp_valid is high for exactly one cycle with rsp_data; the
// receiver cannot stall it.
// configuration: apb registers at 0x0 order, 0x4 length, 0x8 low, 0xc high,
// to be written by the user only while idle; the block does not enforce it.
// reset restores the register defaults and idles the controller; table
// contents are undefined until loaded.
module table_lagrange_interpolator_top #(
   parameter int TABLE_DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  tli_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   output tli_pkg::rsp_payload_type rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [3:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   tli_pkg::cfg_type       cfg_ff;
   tli_pkg::dp_cmd_type    cmd;
   tli_pkg::dp_status_type status;
   logic [IDXW-1:0]        rd_addr;
   logic [1:0]             reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interp_order   <= tli_pkg::ORDER_RESET;
         cfg_ff.table_length   <= tli_pkg::LENGTH_RESET;
         cfg_ff.log_scale_low  <= tli_pkg::LOW_RESET;
         cfg_ff.log_scale_high <= tli_pkg::HIGH_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            tli_pkg::REG_ORDER:  cfg_ff.interp_order   <= pwdata[1:0];
            tli_pkg::REG_LENGTH: cfg_ff.table_length   <= pwdata[11:0];
            tli_pkg::REG_LOW:    cfg_ff.log_scale_low  <= pwdata;
            tli_pkg::REG_HIGH:   cfg_ff.log_scale_high <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tli_pkg::REG_ORDER:  prdata = 32'(cfg_ff.interp_order);
         tli_pkg::REG_LENGTH: prdata = 32'(cfg_ff.table_length);
         tli_pkg::REG_LOW:    prdata = cfg_ff.log_scale_low;
         tli_pkg::REG_HIGH:   prdata = cfg_ff.log_scale_high;
         default:             prdata = '0;
      endcase
   end

   tli_controller #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_query(req_data.req_type),
      .cfg      (cfg_ff),
      .status   (status),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .busy     (busy)
   );

   tli_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .status   (status),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

// File: rtl/core/tli_datapath.sv
module tli_datapath #(
   parameter int TABLE_DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tli_pkg::cfg_type         cfg,
   input  tli_pkg::req_payload_type req_data,
   input  tli_pkg::dp_cmd_type      cmd,
   input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
   output tli_pkg::dp_status_type   status,
   output logic                     rsp_valid,
   output tli_pkg::rsp_payload_type rsp_data
);

   localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [31:0] abs_mem [TABLE_DEPTH];
   logic [63:0] rat_mem [TABLE_DEPTH];
   logic [31:0] rd_t_ff;
   logic [63:0] rd_h_ff;

   logic signed [31:0] x_ff;
   logic signed [31:0] prev_ff;
   logic signed [31:0] t_node_ff [4];
   logic [63:0]        h_node_ff [4];

   logic [tli_pkg::NUMW-1:0] num_ff;
   logic [tli_pkg::NUMW-1:0] den_ff;
   logic                     sign_ff;
   logic [tli_pkg::PW-1:0]   ma_ff;
   logic [tli_pkg::BW-1:0]   mb_ff;
   logic [tli_pkg::PW-1:0]   mp_ff;
   logic [tli_pkg::DVDW-1:0] dvd_ff;
   logic [tli_pkg::REMW-1:0] rem_ff;
   logic [tli_pkg::QW-1:0]   q_ff;
   logic                     ovf_ff;
   logic [tli_pkg::BW-1:0]   w_ff;
   logic [tli_pkg::ACCW-1:0] pos_ff;
   logic [tli_pkg::ACCW-1:0] neg_ff;
   logic [tli_pkg::ACCW-1:0] diff_ff;
   logic                     zero_ff;
   logic                     rsp_valid_ff;
   tli_pkg::rsp_payload_type rsp_ff;

   logic [tli_pkg::MAGW:0]   xd;
   logic [tli_pkg::MAGW:0]   td;
   logic [tli_pkg::REMW-1:0] trial;
   logic                     fits;
   logic [tli_pkg::QW-1:0]   magv;
   logic [tli_pkg::BW-1:0]   w_calc;
   logic [tli_pkg::ACCW:0]   rnd;
   logic [63:0]              sum_out;
   logic                     wr_ok;

   assign xd = tli_pkg::sub_mag(x_ff, t_node_ff[cmd.j]);
   assign td = tli_pkg::sub_mag(t_node_ff[cmd.k], t_node_ff[cmd.j]);

   assign trial = {rem_ff[tli_pkg::REMW-2:0], dvd_ff[tli_pkg::DVDW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   // weight magnitude is the quotient halved with round half up, capped
   assign magv = {1'b0, q_ff[tli_pkg::QW-1:1]} + tli_pkg::QW'(q_ff[0]);
   assign w_calc = (ovf_ff || magv > tli_pkg::QW'(tli_pkg::WEIGHT_LIMIT))
                   ? tli_pkg::WEIGHT_LIMIT : magv[tli_pkg::BW-1:0];

   assign rnd = {1'b0, diff_ff} + tli_pkg::ROUND_HALF;
   assign sum_out = zero_ff ? 64'd0
                  : (|rnd[tli_pkg::ACCW:tli_pkg::FRAC+64]) ? {64{1'b1}}
                  : rnd[tli_pkg::FRAC+63:tli_pkg::FRAC];

   assign wr_ok = 32'(req_data.entry_index) < 32'(TABLE_DEPTH);

   always_comb begin
      status.oob_bounds = (req_data.log_scale < cfg.log_scale_low)
                       || (req_data.log_scale > cfg.log_scale_high);
      status.pair_hit   = (prev_ff <= x_ff) && (x_ff < $signed(rd_t_ff));
      status.ge_last    = x_ff >= $signed(rd_t_ff);
      status.mul_done   = (mb_ff == '0);
      status.dup        = 1'b0;
      for (int a = 0; a < 4; a++) begin
         for (int b = a + 1; b < 4; b++) begin
            if (3'(b) < cmd.m && t_node_ff[a] == t_node_ff[b]) begin
               status.dup = 1'b1;
            end
         end
      end
   end

   // table memories
   always_ff @(posedge clock) begin
      if (cmd.op == tli_pkg::OP_WRITE && wr_ok) begin
         abs_mem[IDXW'(req_data.entry_index)] <= req_data.log_scale;
         rat_mem[IDXW'(req_data.entry_index)] <= req_data.ratio_value;
      end
      rd_t_ff <= abs_mem[rd_addr];
      rd_h_ff <= rat_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.op == tli_pkg::OP_OUT_OOB) || (cmd.op == tli_pkg::OP_OUT_END)
                      || (cmd.op == tli_pkg::OP_OUT_DUP) || (cmd.op == tli_pkg::OP_OUT_SUM);
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         tli_pkg::OP_CAPTURE: begin
            x_ff   <= req_data.log_scale;
            pos_ff <= '0;
            neg_ff <= '0;
         end
         tli_pkg::OP_SCAN: begin
            prev_ff <= rd_t_ff;
         end
         tli_pkg::OP_NODE: begin
            t_node_ff[cmd.slot] <= rd_t_ff;
            h_node_ff[cmd.slot] <= rd_h_ff;
         end
         tli_pkg::OP_WINIT: begin
            num_ff  <= tli_pkg::NUMW'(1);
            den_ff  <= tli_pkg::NUMW'(1);
            sign_ff <= 1'b0;
         end
         tli_pkg::OP_MSTART_NUM: begin
            ma_ff   <= tli_pkg::PW'(num_ff);
            mb_ff   <= tli_pkg::BW'(xd[tli_pkg::MAGW-1:0]);
            mp_ff   <= '0;
            sign_ff <= sign_ff ^ xd[tli_pkg::MAGW];
         end
         tli_pkg::OP_MSTART_DEN: begin
            ma_ff   <= tli_pkg::PW'(den_ff);
            mb_ff   <= tli_pkg::BW'(td[tli_pkg::MAGW-1:0]);
            mp_ff   <= '0;
            sign_ff <= sign_ff ^ td[tli_pkg::MAGW];
         end
         tli_pkg::OP_MSTART_W: begin
            ma_ff <= tli_pkg::PW'(h_node_ff[cmd.k]);
            mb_ff <= w_ff;
            mp_ff <= '0;
         end
         tli_pkg::OP_MSTEP: begin
            if (mb_ff[0]) begin
               mp_ff <= mp_ff + ma_ff;
            end
            ma_ff <= ma_ff << 1;
            mb_ff <= mb_ff >> 1;
         end
         tli_pkg::OP_MEND_NUM: begin
            num_ff <= mp_ff[tli_pkg::NUMW-1:0];
         end
         tli_pkg::OP_MEND_DEN: begin
            den_ff <= mp_ff[tli_pkg::NUMW-1:0];
         end
         tli_pkg::OP_DSTART: begin
            dvd_ff <= {num_ff, tli_pkg::DSHIFT'(0)};
            rem_ff <= '0;
            q_ff   <= '0;
            ovf_ff <= 1'b0;
         end
         tli_pkg::OP_DSTEP: begin
            rem_ff <= fits ? (trial - {1'b0, den_ff}) : trial;
            dvd_ff <= dvd_ff << 1;
            q_ff   <= {q_ff[tli_pkg::QW-2:0], fits};
            ovf_ff <= ovf_ff | q_ff[tli_pkg::QW-1];
         end
         tli_pkg::OP_DEND: begin
            w_ff <= w_calc;
         end
         tli_pkg::OP_ACC: begin
            if (sign_ff) begin
               neg_ff <= neg_ff + tli_pkg::ACCW'(mp_ff);
            end else begin
               pos_ff <= pos_ff + tli_pkg::ACCW'(mp_ff);
            end
         end
         tli_pkg::OP_FIN: begin
            zero_ff <= neg_ff > pos_ff;
            diff_ff <= pos_ff - neg_ff;
         end
         tli_pkg::OP_OUT_OOB: begin
            rsp_ff.ratio_out     <= tli_pkg::ONE_Q30;
            rsp_ff.out_of_bounds <= 1'b1;
            rsp_ff.at_table_end  <= 1'b0;
         end
         tli_pkg::OP_OUT_END: begin
            rsp_ff.ratio_out     <= rd_h_ff;
            rsp_ff.out_of_bounds <= 1'b0;
            rsp_ff.at_table_end  <= 1'b1;
         end
         tli_pkg::OP_OUT_DUP: begin
            rsp_ff.ratio_out     <= h_node_ff[cmd.slot];
            rsp_ff.out_of_bounds <= 1'b0;
            rsp_ff.at_table_end  <= 1'b0;
         end
         tli_pkg::OP_OUT_SUM: begin
            rsp_ff.ratio_out     <= sum_out;
            rsp_ff.out_of_bounds <= 1'b0;
            rsp_ff.at_table_end  <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/core/tli_controller.sv
`include "table_lagrange_interpolator_top_macros.svh"

module tli_controller #(
   parameter int TABLE_DEPTH = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_query,
   input  tli_pkg::cfg_type       cfg,
   input  tli_pkg::dp_status_type status,
   output tli_pkg::dp_cmd_type    cmd,
   output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
   output logic                   busy
);

   localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam int NW   = (CNTW > 12) ? 12 : CNTW;
   localparam int XW   = NW + 1;

   tli_pkg::ctrl_state_type state_ff, state_in;
   logic [NW-1:0] scan_ff, scan_in;
   logic [NW-1:0] i_ff, i_in;
   logic [NW-1:0] s_ff, s_in;
   logic [2:0]    m_ff, m_in;
   logic [2:0]    c_ff, c_in;
   logic [2:0]    k_ff, k_in;
   logic [2:0]    j_ff, j_in;
   logic [7:0]    dcnt_ff, dcnt_in;

   logic [NW-1:0] n;
   logic [XW-1:0] nx;
   logic [1:0]    ord;
   logic [2:0]    mm;
   logic [XW-1:0] sx;
   logic [XW-1:0] lim;
   logic          at_end;
   logic [XW-1:0] stencil_end;

   assign n  = (32'(cfg.table_length) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                          : NW'(cfg.table_length);
   assign nx = {1'b0, n};
   assign stencil_end = {1'b0, s_ff} + XW'(m_ff);

   // stencil size and start, clamped inside the table
   always_comb begin
      at_end = ({1'b0, i_ff} + XW'(1)) >= nx;
      ord    = (cfg.interp_order == 2'd0) ? 2'd1 : cfg.interp_order;
      mm     = {1'b0, ord} + 3'd1;
      if (ord == 2'd3 && ({1'b0, i_ff} + XW'(2)) >= nx) begin
         mm = 3'd3;
      end
      if (XW'(mm) > nx) begin
         mm = 3'(n);
      end
      if (mm >= 3'd3) begin
         sx = (i_ff == '0) ? '0 : ({1'b0, i_ff} - XW'(1));
      end else begin
         sx = {1'b0, i_ff};
      end
      lim = nx - XW'(mm);
      if (sx > lim) begin
         sx = lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tli_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      scan_ff <= scan_in;
      i_ff    <= i_in;
      s_ff    <= s_in;
      m_ff    <= m_in;
      c_ff    <= c_in;
      k_ff    <= k_in;
      j_ff    <= j_in;
      dcnt_ff <= dcnt_in;
   end

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      i_in     = i_ff;
      s_in     = s_ff;
      m_in     = m_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      dcnt_in  = dcnt_ff;
      cmd.op   = tli_pkg::OP_IDLE;
      cmd.slot = 2'd0;
      cmd.m    = m_ff;
      cmd.k    = k_ff[1:0];
      cmd.j    = j_ff[1:0];
      rd_addr  = '0;
      busy     = (state_ff != tli_pkg::ST_IDLE);
      unique case (state_ff)
         tli_pkg::ST_IDLE: begin
            if (start) begin
               if (req_query != tli_pkg::REQ_QUERY) begin
                  cmd.op = tli_pkg::OP_WRITE;
               end else if (status.oob_bounds || n == '0) begin
                  cmd.op = tli_pkg::OP_OUT_OOB;
               end else begin
                  cmd.op   = tli_pkg::OP_CAPTURE;
                  state_in = tli_pkg::ST_SCAN0;
               end
            end
         end
         tli_pkg::ST_SCAN0: begin
            scan_in  = '0;
            state_in = tli_pkg::ST_SCAN;
         end
         tli_pkg::ST_SCAN: begin
            // read data holds entry scan_ff, prev holds the one before
            cmd.op  = tli_pkg::OP_SCAN;
            rd_addr = IDXW'(scan_ff + NW'(1));
            if (scan_ff != '0 && status.pair_hit) begin
               i_in     = scan_ff - NW'(1);
               state_in = tli_pkg::ST_PLAN;
            end else if (scan_ff == n - NW'(1)) begin
               i_in     = status.ge_last ? (n - NW'(1)) : '0;
               state_in = tli_pkg::ST_PLAN;
            end else begin
               scan_in = scan_ff + NW'(1);
            end
         end
         tli_pkg::ST_PLAN: begin
            if (at_end) begin
               state_in = tli_pkg::ST_END_RD;
            end else begin
               s_in     = NW'(sx);
               m_in     = mm;
               c_in     = 3'd0;
               state_in = tli_pkg::ST_NODE;
            end
         end
         tli_pkg::ST_END_RD: begin
            rd_addr  = IDXW'(i_ff);
            state_in = tli_pkg::ST_END_OUT;
         end
         tli_pkg::ST_END_OUT: begin
            cmd.op   = tli_pkg::OP_OUT_END;
            state_in = tli_pkg::ST_IDLE;
         end
         tli_pkg::ST_NODE: begin
            rd_addr = IDXW'(s_ff + NW'(c_ff));
            if (c_ff != 3'd0) begin
               cmd.op   = tli_pkg::OP_NODE;
               cmd.slot = 2'(c_ff - 3'd1);
            end
            c_in = c_ff + 3'd1;
            if (c_ff == m_ff) begin
               state_in = tli_pkg::ST_DUP;
            end
         end
         tli_pkg::ST_DUP: begin
            if (status.dup) begin
               cmd.op   = tli_pkg::OP_OUT_DUP;
               cmd.slot = 2'(i_ff - s_ff);
               state_in = tli_pkg::ST_IDLE;
            end else begin
               k_in     = 3'd0;
               state_in = tli_pkg::ST_WINIT;
            end
         end
         tli_pkg::ST_WINIT: begin
            cmd.op   = tli_pkg::OP_WINIT;
            j_in     = 3'd0;
            state_in = tli_pkg::ST_JSEL;
         end
         tli_pkg::ST_JSEL: begin
            if (j_ff == m_ff) begin
               state_in = tli_pkg::ST_DIV;
            end else if (j_ff == k_ff) begin
               j_in = j_ff + 3'd1;
            end else begin
               state_in = tli_pkg::ST_MNUM;
            end
         end
         tli_pkg::ST_MNUM: begin
            cmd.op   = tli_pkg::OP_MSTART_NUM;
            state_in = tli_pkg::ST_MNUM_RUN;
         end
         tli_pkg::ST_MNUM_RUN: begin
            if (status.mul_done) begin
               cmd.op   = tli_pkg::OP_MEND_NUM;
               state_in = tli_pkg::ST_MDEN;
            end else begin
               cmd.op = tli_pkg::OP_MSTEP;
            end
         end
         tli_pkg::ST_MDEN: begin
            cmd.op   = tli_pkg::OP_MSTART_DEN;
            state_in = tli_pkg::ST_MDEN_RUN;
         end
         tli_pkg::ST_MDEN_RUN: begin
            if (status.mul_done) begin
               cmd.op   = tli_pkg::OP_MEND_DEN;
               j_in     = j_ff + 3'd1;
               state_in = tli_pkg::ST_JSEL;
            end else begin
               cmd.op = tli_pkg::OP_MSTEP;
            end
         end
         tli_pkg::ST_DIV: begin
            cmd.op   = tli_pkg::OP_DSTART;
            dcnt_in  = 8'd0;
            state_in = tli_pkg::ST_DIV_RUN;
         end
         tli_pkg::ST_DIV_RUN: begin
            cmd.op  = tli_pkg::OP_DSTEP;
            dcnt_in = dcnt_ff + 8'd1;
            if (dcnt_ff == 8'(tli_pkg::DIV_STEPS - 1)) begin
               state_in = tli_pkg::ST_DEND;
            end
         end
         tli_pkg::ST_DEND: begin
            cmd.op   = tli_pkg::OP_DEND;
            state_in = tli_pkg::ST_MW;
         end
         tli_pkg::ST_MW: begin
            cmd.op   = tli_pkg::OP_MSTART_W;
            state_in = tli_pkg::ST_MW_RUN;
         end
         tli_pkg::ST_MW_RUN: begin
            if (status.mul_done) begin
               cmd.op = tli_pkg::OP_ACC;
               if (k_ff + 3'd1 == m_ff) begin
                  state_in = tli_pkg::ST_FIN;
               end else begin
                  k_in     = k_ff + 3'd1;
                  state_in = tli_pkg::ST_WINIT;
               end
            end else begin
               cmd.op = tli_pkg::OP_MSTEP;
            end
         end
         tli_pkg::ST_FIN: begin
            cmd.op   = tli_pkg::OP_FIN;
            state_in = tli_pkg::ST_OUT;
         end
         tli_pkg::ST_OUT: begin
            cmd.op   = tli_pkg::OP_OUT_SUM;
            state_in = tli_pkg::ST_IDLE;
         end
         default: begin
            state_in = tli_pkg::ST_IDLE;
         end
      endcase
   end

   `TLI_ASSERT_IMP(a_scan_in_table, clock, reset, state_ff == tli_pkg::ST_SCAN, scan_ff < n)
   `TLI_ASSERT_IMP(a_stencil_fits, clock, reset, state_ff == tli_pkg::ST_WINIT, (m_ff >= 3'd2) && (stencil_end <= nx))
   `TLI_ASSERT_IMP(a_weight_index, clock, reset, state_ff == tli_pkg::ST_MW, k_ff < m_ff)
   `TLI_ASSERT_NEXT(a_sum_to_idle, clock, reset, state_ff == tli_pkg::ST_OUT, state_ff == tli_pkg::ST_IDLE)

endmodule

// File: test/tli_checker.sv
`timescale 1ns / 1ps

module tli_checker
   import tli_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            busy,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  rsp_payload_type rsp_data,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [3:0]      paddr,
   input  logic [31:0]     pwdata,
   input  logic            pready,
   output int              errors,
   output int              pending
);

   logic signed [31:0] abscissa_mem [2048];
   logic [63:0]        ratio_mem [2048];
   logic [1:0]         order_reg;
   logic [11:0]        length_reg;
   logic signed [31:0] low_reg;
   logic signed [31:0] high_reg;
   rsp_payload_type    ratio_queue [$];

   initial begin
      errors = 0;
      pending = 0;
      for (int i = 0; i < 2048; i++) begin
         abscissa_mem[i] = '0;
         ratio_mem[i] = '0;
      end
   end

   function automatic rsp_payload_type interpolate_ratio(input logic signed [31:0] xq);
      rsp_payload_type res;
      int n, i, m, s, ord, negs;
      bit found, dup;
      longint x, d;
      longint nd [4];
      logic [191:0] num, den, q, mag, pos, neg, sum;
      res.ratio_out = ONE_Q30;
      res.out_of_bounds = 1'b1;
      res.at_table_end = 1'b0;
      x = longint'(xq);
      n = (length_reg > 2048) ? 2048 : int'(length_reg);
      if (xq < low_reg || xq > high_reg || n == 0) return res;
      res.out_of_bounds = 1'b0;
      found = 0;
      i = 0;
      for (int j = 0; j + 1 < n && !found; j++) begin
         if (abscissa_mem[j] <= xq && xq < abscissa_mem[j+1]) begin
            i = j;
            found = 1;
         end
      end
      if (!found) i = (xq >= abscissa_mem[n-1]) ? n - 1 : 0;
      if (i + 1 >= n) begin
         res.ratio_out = ratio_mem[i];
         res.at_table_end = 1'b1;
         return res;
      end
      ord = (order_reg == 0) ? 1 : int'(order_reg);
      m = ord + 1;
      if (ord == 3 && i + 2 >= n) m = 3;
      if (m > n) m = n;
      s = (m >= 3) ? i - 1 : i;
      if (s < 0) s = 0;
      if (s > n - m) s = n - m;
      dup = 0;
      for (int j = 0; j < m; j++)
         for (int k = j + 1; k < m; k++)
            if (abscissa_mem[s+j] == abscissa_mem[s+k]) dup = 1;
      if (dup) begin
         res.ratio_out = ratio_mem[i];
         return res;
      end
      for (int k = 0; k < m; k++) nd[k] = longint'(abscissa_mem[s+k]);
      pos = '0;
      neg = '0;
      for (int k = 0; k < m; k++) begin
         num = 1;
         den = 1;
         negs = 0;
         for (int j = 0; j < m; j++) begin
            if (j != k) begin
               d = x - nd[j];
               if (d < 0) begin
                  negs++;
                  d = -d;
               end
               num = num * 192'(d);
               d = nd[k] - nd[j];
               if (d < 0) begin
                  negs++;
                  d = -d;
               end
               den = den * 192'(d);
            end
         end
         q = (num << 31) / den;
         // weight rounded half away from zero, magnitude capped at 1024.0
         if (q[191:64] != 0) mag = 192'(WEIGHT_LIMIT);
         else mag = (q >> 1) + q[0];
         if (mag > 192'(WEIGHT_LIMIT)) mag = 192'(WEIGHT_LIMIT);
         if (negs[0]) neg = neg + mag * 192'(ratio_mem[s+k]);
         else pos = pos + mag * 192'(ratio_mem[s+k]);
      end
      if (neg > pos) begin
         res.ratio_out = '0;
         return res;
      end
      sum = (pos - neg + 192'(64'h2000_0000)) >> FRAC;
      res.ratio_out = (sum[191:64] != 0) ? '1 : sum[63:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         order_reg = ORDER_RESET;
         length_reg = LENGTH_RESET;
         low_reg = LOW_RESET;
         high_reg = HIGH_RESET;
         ratio_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_ORDER:  order_reg = pwdata[1:0];
               REG_LENGTH: length_reg = pwdata[11:0];
               REG_LOW:    low_reg = pwdata;
               REG_HIGH:   high_reg = pwdata;
            endcase
         end
         if (rsp_valid) begin
            if (ratio_queue.size() == 0) begin
               errors++;
               $display("%0t unexpected response: expected none actual %h", $time, rsp_data);
            end else begin
               want = ratio_queue.pop_front();
               if (rsp_data.ratio_out !== want.ratio_out) begin
                  errors++;
                  $display("%0t ratio_out: expected %h actual %h", $time,
                           want.ratio_out, rsp_data.ratio_out);
               end
               if (rsp_data.out_of_bounds !== want.out_of_bounds) begin
                  errors++;
                  $display("%0t out_of_bounds: expected %b actual %b", $time,
                           want.out_of_bounds, rsp_data.out_of_bounds);
               end
               if (rsp_data.at_table_end !== want.at_table_end) begin
                  errors++;
                  $display("%0t at_table_end: expected %b actual %b", $time,
                           want.at_table_end, rsp_data.at_table_end);
               end
            end
         end
         if (start && !busy) begin
            if (req_data.req_type == REQ_LOAD) begin
               abscissa_mem[req_data.entry_index] = req_data.log_scale;
               ratio_mem[req_data.entry_index] = req_data.ratio_value;
            end else begin
               ratio_queue.push_back(interpolate_ratio(req_data.log_scale));
            end
         end
      end
      pending = ratio_queue.size();
   end

   final begin
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tli_pkg::*;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_data;
   logic            rsp_valid;
   rsp_payload_type rsp_data;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [3:0]      paddr;
   logic [31:0]     pwdata;
   logic [31:0]     prdata;
   logic            pready;
   int              errors;
   int              pending;

   longint table_x [2048];
   int     burst_left;

   table_lagrange_interpolator_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   tli_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
      .errors(errors), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic send_req(input req_payload_type r);
      @(negedge clock);
      start = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 2) != 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
      end
   endtask

   task automatic load_entry(input int idx, input longint xv, input logic [63:0] ratio);
      req_payload_type r;
      r.req_type = REQ_LOAD;
      r.entry_index = 11'(idx);
      r.log_scale = 32'(xv);
      r.ratio_value = ratio;
      table_x[idx] = longint'(r.log_scale);
      send_req(r);
   endtask

   task automatic query(input longint xv);
      req_payload_type r;
      if (xv > 64'sd2147483647) xv = 64'sd2147483647;
      if (xv < -64'sd2147483648) xv = -64'sd2147483648;
      r.req_type = REQ_QUERY;
      r.entry_index = 11'($urandom);
      r.log_scale = 32'(xv);
      r.ratio_value = {$urandom, $urandom};
      send_req(r);
   endtask

   // wait for the block to drain before touching the registers
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 2'b00};
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_regs(input int ord, input int len, input longint lo, input longint hi);
      settle();
      csr_write(REG_ORDER, 32'(ord));
      csr_write(REG_LENGTH, 32'(len));
      csr_write(REG_LOW, 32'(lo));
      csr_write(REG_HIGH, 32'(hi));
   endtask

   function automatic logic [63:0] rand_ratio();
      case ($urandom_range(0, 3))
         0: rand_ratio = {$urandom, $urandom};
         1: rand_ratio = {32'($urandom_range(0, 15)), $urandom};
         default: rand_ratio = {32'd0, $urandom} << $urandom_range(0, 30);
      endcase
   endfunction

   // sorted abscissas with random steps, now and then a repeated node
   task automatic load_sorted(input int n, input longint base, input int max_step);
      longint xv;
      xv = base;
      for (int i = 0; i < n; i++) begin
         load_entry(i, xv, rand_ratio());
         if ($urandom_range(0, 30) == 0) xv = xv;
         else xv = xv + $urandom_range(1, max_step);
      end
   endtask

   task automatic near_query(input int n);
      longint xv;
      xv = table_x[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 9))
         0: query(xv);
         1: query(longint'($signed($urandom)));
         2: query(xv + longint'($signed($urandom)) / 64);
         default: query(xv + $urandom_range(0, 1 << 24) - (1 << 22));
      endcase
   endtask

   initial begin
      int n, ord;
      longint lo, hi;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      burst_left = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // empty table with reset bounds, then out of bounds on both sides
      query(-(64'sd1 << 28));
      query(-64'sd2147483648);
      query(64'sd2147483647);
      query(64'sd0);

      // four-entry table, full bounds
      load_entry(0, -64'sd2147483648, 64'd0);
      load_entry(1, -(64'sd1 << 28), 64'hFFFF_FFFF_FFFF_FFFF);
      load_entry(2, 64'sd1 << 28, ONE_Q30);
      load_entry(3, 64'sd2147483647, 64'h0000_0003_0000_0000);
      for (ord = 0; ord < 4; ord++) begin
         set_regs(ord, 4, -64'sd2147483648, 64'sd2147483647);
         query(-64'sd2147483648);
         query(64'sd0);
         query(64'sd2147483647);
         query(-(64'sd1 << 28) + 5);
      end
      // short tables
      set_regs(3, 1, -64'sd2147483648, 64'sd2147483647);
      query(-64'sd5);
      query(-64'sd2147483648);
      set_regs(3, 2, -(64'sd1 << 27), 64'sd1 << 27);
      query(64'sd0);
      query((64'sd1 << 27) + 1);
      // repeated node in the stencil
      load_entry(2, -(64'sd1 << 28), 64'd77);
      set_regs(2, 4, -64'sd2147483648, 64'sd2147483647);
      query(-(64'sd1 << 28));
      query(64'sd1000);

      // random tables
      for (int ph = 0; ph < 39; ph++) begin
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         settle();
         load_sorted(n, longint'($signed($urandom)) / 4, 1 << $urandom_range(4, 24));
         // noise loads outside the active prefix
         repeat ($urandom_range(0, 3))
            load_entry($urandom_range(n, 2047), longint'($signed($urandom)), {$urandom, $urandom});
         if ($urandom_range(0, 3) == 0) begin
            lo = table_x[0] + $urandom_range(0, 1 << 20) - (1 << 19);
            hi = table_x[n-1] + $urandom_range(0, 1 << 20) - (1 << 19);
         end else begin
            lo = -64'sd2147483648;
            hi = 64'sd2147483647;
         end
         set_regs($urandom_range(0, 3), n, lo, hi);
         repeat ($urandom_range(6, 14)) near_query(n);
      end

      settle();
      repeat (50) @(negedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("tb: failure");
      $finish;
   end

endmodule
